>>> rtl/stcp_pkg.sv
// Types, character codes and decode helpers shared by the serial time command parser.
// No dependencies; every rtl file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package stcp_pkg;

    // Field and register widths
    localparam int TIMEOUT_W   = 20;
    localparam int HELP_W      = 7;
    localparam int CFG_INDEX_W = 2;

    // Reset values of the configuration registers
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd150000;
    localparam logic [HELP_W-1:0]    HELP_RESET    = 7'd10;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HELP_INTERVAL = 2'd1;

    // Default line capacity
    localparam int LINE_CAPACITY_DEF = 30;

    // Length of a valid set line; only the first SET_LEN bytes are ever compared
    localparam int SET_LEN  = 21;
    localparam int STORE_AW = $clog2(SET_LEN);
    localparam int DBG_LEN  = 7;

    // Character codes
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    // Command prefixes: "set " and "debug "
    localparam logic [7:0] PFX_SET [0:3] = '{8'h73, 8'h65, 8'h74, 8'h20};
    localparam logic [7:0] PFX_DBG [0:5] = '{8'h64, 8'h65, 8'h62, 8'h75, 8'h67, 8'h20};

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_SET_TIME  = 3'd1,
        KIND_DEBUG_OFF = 3'd2,
        KIND_DEBUG_ON  = 3'd3,
        KIND_TOO_LONG  = 3'd4,
        KIND_TOO_SHORT = 3'd5,
        KIND_HELP      = 3'd6
    } kind_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] echo_byte;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic       debug_enabled;
        logic       last;
    } out_item_t;

    // Decode two ASCII digits as tens * 10 + ones, wrapping to 8 bits
    function automatic logic [7:0] two_digits(input logic [7:0] tens, input logic [7:0] ones);
        logic [7:0] t;
        logic [7:0] o;
        t = tens - CHAR_ZERO;
        o = ones - CHAR_ZERO;
        return (t << 3) + (t << 1) + o;
    endfunction

    // Result with all payload fields cleared but kind, echo and flag
    function automatic out_item_t make_result(input kind_t kind, input logic [7:0] echo,
                                              input logic dbg);
        out_item_t r;
        r               = '0;
        r.kind          = kind;
        r.echo_byte     = echo;
        r.debug_enabled = dbg;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/serial_time_command_parser.sv
// Serial time command parser: line assembly, command match, set-time decode, result queue.
// Depends on stcp_pkg for item types, character codes and the digit decoder.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   s_valid/s_ready/s_item take one beat per received byte or time tick.
//   m_valid/m_ready/m_item return the results; m_item.last marks the final
//   result of an input beat. A beat yields zero to three results.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write timeout_ticks (index 0) and
//   help_interval (index 1); cfg_ready is always high, other indexes are ignored.
// The first result of a beat is registered and is on m_item in the cycle after acceptance.
// Throughput: one input beat per cycle while each beat yields at most one
//   result and m_ready is high; a beat with several results holds the result
//   queue until they have left, and the next beat is taken in the cycle its last result leaves.
// The line is matched and decoded in the accepting cycle from a register file
//   of the first 21 line bytes.
// Reset (aresetn low, synchronous) empties the result queue, closes the line,
//   clears the debug flag and loads the configuration defaults.
// When the receiver stalls, results wait in the three-entry queue and s_ready
//   drops until the queue is about to empty.
module serial_time_command_parser #(
    parameter int LINE_CAPACITY = stcp_pkg::LINE_CAPACITY_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  stcp_pkg::in_item_t                   s_item,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output stcp_pkg::out_item_t                  m_item,

    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [stcp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [stcp_pkg::TIMEOUT_W-1:0]        cfg_data
);

    localparam int FILL_W = $clog2(LINE_CAPACITY);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(LINE_CAPACITY - 1);
    localparam logic [FILL_W-1:0] FILL_SET  = FILL_W'(stcp_pkg::SET_LEN);

    // Configuration
    logic [stcp_pkg::TIMEOUT_W-1:0] timeout_ticks_reg;
    logic [stcp_pkg::HELP_W-1:0]    help_interval_reg;

    // Parser state
    logic [7:0]                     store_reg [0:stcp_pkg::SET_LEN-1];
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic                           active_reg, active_next;
    logic [stcp_pkg::TIMEOUT_W-1:0] timeout_left_reg, timeout_left_next;
    logic [stcp_pkg::HELP_W-1:0]    help_count_reg, help_count_next;
    logic                           debug_reg, debug_next;

    // Result queue
    stcp_pkg::out_item_t            res_reg [0:2];
    stcp_pkg::out_item_t            res_next [0:2];
    logic [1:0]                     cnt_reg;
    logic [1:0]                     new_cnt;

    logic                           accept;
    logic                           pop;
    logic                           store_we;
    logic                           is_set;
    logic                           is_dbg;
    stcp_pkg::out_item_t            cmd_res;
    logic                           cmd_hit;

    assign cfg_ready = 1'b1;
    assign m_valid   = (cnt_reg != 2'd0);
    assign m_item    = res_reg[0];
    assign pop       = m_valid && m_ready;
    assign s_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign accept    = s_valid && s_ready;

    // Prefix matches over the stored line
    always_comb begin
        is_set = (fill_reg >= FILL_W'(4));
        for (int i = 0; i < 4; i++) begin
            if (store_reg[i] != stcp_pkg::PFX_SET[i]) begin
                is_set = 1'b0;
            end
        end
        is_dbg = (fill_reg >= FILL_W'(stcp_pkg::DBG_LEN));
        for (int i = 0; i < 6; i++) begin
            if (store_reg[i] != stcp_pkg::PFX_DBG[i]) begin
                is_dbg = 1'b0;
            end
        end
    end

    // Command result for a carriage return
    always_comb begin
        cmd_res    = stcp_pkg::make_result(stcp_pkg::KIND_ECHO, 8'd0, debug_reg);
        cmd_hit    = 1'b0;
        debug_next = debug_reg;
        priority if (is_set) begin
            cmd_hit = 1'b1;
            priority if (fill_reg > FILL_SET) begin
                cmd_res.kind = stcp_pkg::KIND_TOO_LONG;
            end else if (fill_reg < FILL_SET) begin
                cmd_res.kind = stcp_pkg::KIND_TOO_SHORT;
            end else begin
                cmd_res.kind   = stcp_pkg::KIND_SET_TIME;
                cmd_res.year   = stcp_pkg::two_digits(store_reg[4], store_reg[5]);
                cmd_res.month  = stcp_pkg::two_digits(store_reg[7], store_reg[8]);
                cmd_res.day    = stcp_pkg::two_digits(store_reg[10], store_reg[11]);
                cmd_res.hour   = stcp_pkg::two_digits(store_reg[13], store_reg[14]);
                cmd_res.minute = stcp_pkg::two_digits(store_reg[16], store_reg[17]);
                cmd_res.second = stcp_pkg::two_digits(store_reg[19], store_reg[20]);
            end
        end else if (is_dbg && store_reg[6] == stcp_pkg::CHAR_ZERO) begin
            cmd_hit               = 1'b1;
            debug_next            = 1'b0;
            cmd_res.kind          = stcp_pkg::KIND_DEBUG_OFF;
            cmd_res.debug_enabled = 1'b0;
        end else if (is_dbg && store_reg[6] == stcp_pkg::CHAR_ONE) begin
            cmd_hit               = 1'b1;
            debug_next            = 1'b1;
            cmd_res.kind          = stcp_pkg::KIND_DEBUG_ON;
            cmd_res.debug_enabled = 1'b1;
        end else begin
            cmd_hit = 1'b0;
        end
    end

    // Next state and results of one input beat
    always_comb begin
        fill_next         = fill_reg;
        active_next       = active_reg;
        timeout_left_next = timeout_left_reg;
        help_count_next   = help_count_reg;
        store_we          = 1'b0;
        new_cnt           = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res_next[i] = stcp_pkg::make_result(stcp_pkg::KIND_ECHO, 8'd0, debug_reg);
        end
        unique case (s_item.cmd)
            stcp_pkg::CMD_TICK: begin
                if (active_reg) begin
                    if (timeout_left_reg <= stcp_pkg::TIMEOUT_W'(1)) begin
                        active_next       = 1'b0;
                        fill_next         = '0;
                        timeout_left_next = '0;
                    end else begin
                        timeout_left_next = timeout_left_reg - 1'b1;
                    end
                end else if (help_count_reg == '0) begin
                    help_count_next = help_interval_reg;
                    res_next[0]     = stcp_pkg::make_result(stcp_pkg::KIND_HELP, 8'd0,
                                                            debug_reg);
                    new_cnt         = 2'd1;
                end else begin
                    help_count_next = help_count_reg - 1'b1;
                end
            end
            stcp_pkg::CMD_BYTE: begin
                // fill_reg is already zero while no line is open
                active_next       = 1'b1;
                timeout_left_next = timeout_ticks_reg;
                res_next[0]       = stcp_pkg::make_result(stcp_pkg::KIND_ECHO, s_item.rx_byte,
                                                          debug_reg);
                priority if (s_item.rx_byte == stcp_pkg::CHAR_BS) begin
                    res_next[1] = stcp_pkg::make_result(stcp_pkg::KIND_ECHO,
                                                        stcp_pkg::CHAR_SPACE, debug_reg);
                    res_next[2] = stcp_pkg::make_result(stcp_pkg::KIND_ECHO,
                                                        stcp_pkg::CHAR_BS, debug_reg);
                    new_cnt     = 2'd3;
                    if (fill_reg != '0) begin
                        fill_next = fill_reg - 1'b1;
                    end
                end else if (s_item.rx_byte == stcp_pkg::CHAR_CR) begin
                    res_next[1] = cmd_res;
                    new_cnt     = cmd_hit ? 2'd2 : 2'd1;
                    active_next = 1'b0;
                    fill_next   = '0;
                end else begin
                    new_cnt  = 2'd1;
                    store_we = (fill_reg < FILL_SET);
                    // drop the line once it fills the capacity
                    if (fill_reg == FILL_LAST) begin
                        active_next = 1'b0;
                        fill_next   = '0;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            default: begin
                new_cnt = 2'd0;
            end
        endcase
        if (new_cnt != 2'd0) begin
            res_next[new_cnt - 2'd1].last = 1'b1;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= stcp_pkg::TIMEOUT_RESET;
            help_interval_reg <= stcp_pkg::HELP_RESET;
            fill_reg          <= '0;
            active_reg        <= 1'b0;
            timeout_left_reg  <= stcp_pkg::TIMEOUT_RESET;
            help_count_reg    <= stcp_pkg::HELP_RESET;
            debug_reg         <= 1'b0;
            cnt_reg           <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == stcp_pkg::CFG_TIMEOUT_TICKS) begin
                    timeout_ticks_reg <= cfg_data;
                end
                if (cfg_index == stcp_pkg::CFG_HELP_INTERVAL) begin
                    help_interval_reg <= cfg_data[stcp_pkg::HELP_W-1:0];
                end
            end
            if (accept) begin
                fill_reg         <= fill_next;
                active_reg       <= active_next;
                timeout_left_reg <= timeout_left_next;
                help_count_reg   <= help_count_next;
                if (s_item.cmd == stcp_pkg::CMD_BYTE && s_item.rx_byte == stcp_pkg::CHAR_CR) begin
                    debug_reg <= debug_next;
                end
                cnt_reg <= new_cnt;
            end else if (pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Line bytes and result queue payload
    always_ff @(posedge aclk) begin
        if (accept && store_we) begin
            store_reg[fill_reg[stcp_pkg::STORE_AW-1:0]] <= s_item.rx_byte;
        end
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= res_next[i];
            end
        end else if (pop) begin
            // advance the queue by one result
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

`default_nettype wire
